@@ sv/csum_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Checksum engine package
// Request types, operation codes and widths shared by the checksum modules.
// ----------------------------------------------------------------------------
package csum_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned BYTE_W = 8;

   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_SEED = 2'd2
   } mode_type;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      mode_type mode;
      word_type data_word;
      logic     single_byte;
      logic     last;
   } req_type;

endpackage : csum_pkg
`default_nettype wire

@@ sv/csum_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Checksum update unit
// Ones-complement add with end-around carry, incremental subtract and seed
// load of the running sum for one request.
// ----------------------------------------------------------------------------
module csum_alu (
   input  var csum_pkg::req_type  req,
   input  var csum_pkg::word_type sum,
   output var csum_pkg::word_type next_sum
);
   import csum_pkg::*;

   word_type        operand;
   logic [WORD_W:0] add_full;
   logic [WORD_W:0] sub_full;
   word_type        add_res;
   word_type        sub_res;
   logic            sub_gt;

   // lone trailing byte: second byte is zero
   assign operand  = req.single_byte ? {{(WORD_W-BYTE_W){1'b0}}, req.data_word[BYTE_W-1:0]}
                                     : req.data_word;
   assign add_full = {1'b0, sum} + {1'b0, operand};
   assign add_res  = add_full[WORD_W] ? (add_full[WORD_W-1:0] + word_type'(1))
                                      : add_full[WORD_W-1:0];
   assign sub_full = {1'b0, sum} - {1'b0, operand};
   assign sub_gt   = !sub_full[WORD_W] && (sub_full[WORD_W-1:0] != '0);
   // zero or negative difference takes one more off
   assign sub_res  = sub_gt ? sub_full[WORD_W-1:0]
                            : (sub_full[WORD_W-1:0] - word_type'(1));

   always_comb begin
      case (req.mode)
         MODE_ADD:  next_sum = add_res;
         MODE_SUB:  next_sum = sub_res;
         MODE_SEED: next_sum = ~req.data_word;
         default:   next_sum = sum;
      endcase
   end

endmodule : csum_alu
`default_nettype wire

@@ sv/ones_complement_checksum_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ones-complement checksum engine
// Streaming 16-bit Internet checksum with add, subtract and seed requests.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while no tlast request is stalled. A
// request passes an input register, then the accumulator update (a 17-bit
// add or subtract plus a one-step correction, all combinational), and a
// request with tlast loads the checksum into the result register.
// The result register holds a waiting checksum while further requests keep
// flowing; only a tlast request stalls, and only while the previous result
// is still held. The accumulator returns to zero after each tlast request.
module ones_complement_checksum_engine (
   input  var logic                clock,
   input  var logic                reset,
   // request channel
   input  var logic                req_tvalid,
   output var logic                req_tready,
   input  var logic [15:0]         req_tdata,   // [15:0] data_word
   input  var logic [2:0]          req_tuser,   // [1:0] mode, [2] single_byte
   input  var logic                req_tlast,
   // result channel
   output var logic                rsp_tvalid,
   input  var logic                rsp_tready,
   output var logic [15:0]         rsp_tdata,   // [15:0] checksum
   // configuration: complement_result
   input  var logic                csr_valid,
   output var logic                csr_ready,
   input  var logic                csr_wdata
);
   import csum_pkg::*;

   req_type  in_req_ff,   in_req_in;
   logic     in_valid_ff, in_valid_in;
   word_type sum_ff,      sum_in;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_data_ff,  rsp_data_in;
   logic     cmpl_ff,      cmpl_in;
   word_type next_sum;
   req_type  req_word;
   logic     core_fire;

   assign req_word.mode        = mode_type'(req_tuser[1:0]);
   assign req_word.data_word   = req_tdata;
   assign req_word.single_byte = req_tuser[2];
   assign req_word.last        = req_tlast;

   // non-last requests never need the result register
   assign core_fire  = in_valid_ff && (!in_req_ff.last || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || core_fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   csum_alu u_alu (
      .req      (in_req_ff),
      .sum      (sum_ff),
      .next_sum (next_sum)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmpl_in      = cmpl_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_req_in   = req_word;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_fire) begin
         sum_in = in_req_ff.last ? '0 : next_sum;
         if (in_req_ff.last) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = cmpl_ff ? ~next_sum : next_sum;
         end
      end
      if (csr_valid && csr_ready) begin
         cmpl_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmpl_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         cmpl_ff      <= cmpl_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff   <= in_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      core_fire && in_req_ff.last |=> sum_ff == '0)
      else $error("accumulator not cleared after run end");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      core_fire && in_req_ff.last |=> rsp_valid_ff)
      else $error("run end did not produce a result");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !core_fire |=> $stable(sum_ff))
      else $error("accumulator changed without a request");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(core_fire && in_req_ff.last))
      else $error("held result overwritten");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input register empty but request not taken");

endmodule : ones_complement_checksum_engine
`default_nettype wire
